/* rtl/dfpbn_pkg.sv */
// Shared constants and stage types for the double bitwise-NOT pipeline.
`timescale 1ns / 1ps
package dfpbn_pkg;

    localparam int unsigned MANT_BITS = 52;
    localparam int unsigned EXP_BITS  = 11;
    localparam logic [EXP_BITS-1:0] EXP_SPECIAL = 11'h7FF;
    localparam logic [12:0] EXP_BIAS = 13'd1023;
    // biased exponent of 2^31, the weight of the top bit of the 32-bit word
    localparam logic [EXP_BITS-1:0] EXP_TOP = 11'd1054;
    localparam int unsigned FRAC_POINT = 21;
    localparam int unsigned LZ_BITS = 6;

    typedef struct packed {
        logic        sign;
        logic        mag_nz;
        logic        special;
        logic        whole;
        logic [31:0] low;
        logic [63:0] aligned;
    } s1_t;

    typedef struct packed {
        logic                zero;
        logic [LZ_BITS-1:0]  lz;
        logic [MANT_BITS:0]  word;
    } s3_t;

endpackage

/* rtl/dfpbn_lzc.sv */
// Leading-zero count over the 53-bit significand word.
`timescale 1ns / 1ps
module dfpbn_lzc
    import dfpbn_pkg::*;
(
    input  logic [MANT_BITS:0]   word,
    output logic [LZ_BITS-1:0]   lz,
    output logic                 zero
);
    always_comb begin
        lz   = '0;
        zero = 1'b1;
        for (int i = 0; i <= MANT_BITS; i++) begin
            if (word[i]) begin
                lz   = LZ_BITS'(MANT_BITS - i);
                zero = 1'b0;
            end
        end
    end
endmodule

/* rtl/double_fixed_point_bitwise_not.sv */
// Top level: four-stage pipeline returning the double of ~(uint32)x.
// One operand per cycle unless the output stalls; stages are decode/align,
// negate/invert, leading-zero count, normalize/pack. The whole pipeline
// holds while a result waits on m_ready.
`timescale 1ns / 1ps
module double_fixed_point_bitwise_not
    import dfpbn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_operand_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_bits
);
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    s1_t  s1_reg, s1_next;
    logic [MANT_BITS:0] w2_reg, w2_next;
    s3_t  s3_reg, s3_next;
    logic [63:0] res_reg, res_next;

    assign en      = !v4_reg || m_ready;
    assign s_ready = en;
    assign m_valid = v4_reg;
    assign m_result_bits = res_reg;

    // stage 1: decode and align
    logic [EXP_BITS-1:0] expf;
    logic signed [12:0]  e;
    logic [MANT_BITS:0]  mant;
    logic [51:0]         frac_sh;
    logic [12:0]         rsh;
    always_comb begin
        expf = s_operand_bits[62:52];
        e    = $signed({2'b00, expf}) - $signed(EXP_BIAS);
        mant = {1'b1, s_operand_bits[51:0]};
        frac_sh = s_operand_bits[51:0] << e[5:0];
        s1_next.sign    = s_operand_bits[63];
        s1_next.mag_nz  = |s_operand_bits[62:0];
        s1_next.special = (expf == EXP_SPECIAL);
        s1_next.whole   = (e >= 0) && ((e >= 52) || (frac_sh == '0));
        if (e >= 52) begin
            s1_next.low = (e >= 84) ? 32'd0 : 32'((85'(mant)) << (e - 13'sd52));
        end else begin
            s1_next.low = 32'(mant >> 6'(13'sd52 - e));
        end
        rsh = 13'(13'sd31 - e);
        if (e <= 31) begin
            s1_next.aligned = (rsh > 13'd52) ? 64'd0 : (64'(mant) >> rsh[5:0]);
        end else begin
            s1_next.aligned = 64'(mant) << 5'(e - 13'sd31);
        end
    end

    // stage 2: negate, invert, select
    logic [31:0] l2;
    logic [63:0] m2;
    always_comb begin
        l2 = s1_reg.sign ? (32'd0 - s1_reg.low) : s1_reg.low;
        m2 = (s1_reg.sign && s1_reg.mag_nz) ? (64'd0 - s1_reg.aligned) : s1_reg.aligned;
        if (s1_reg.special) begin
            w2_next = s1_reg.sign ? '0 : {32'hFFFF_FFFF, {FRAC_POINT{1'b0}}};
        end else if (s1_reg.whole) begin
            w2_next = {~l2, {FRAC_POINT{1'b0}}};
        end else begin
            w2_next = ~m2[MANT_BITS:0];
        end
    end

    // stage 3: leading-zero count
    logic [LZ_BITS-1:0] lz3_next;
    logic               zero3_next;
    dfpbn_lzc u_lzc (
        .word (w2_reg),
        .lz   (lz3_next),
        .zero (zero3_next)
    );
    always_comb begin
        s3_next.zero = zero3_next;
        s3_next.lz   = lz3_next;
        s3_next.word = w2_reg;
    end

    // stage 4: normalize and pack
    logic [MANT_BITS:0] nrm;
    always_comb begin
        nrm = s3_reg.word << s3_reg.lz;
        if (s3_reg.zero) begin
            res_next = '0;
        end else begin
            res_next = {1'b0, EXP_TOP - EXP_BITS'(s3_reg.lz), nrm[MANT_BITS-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= s1_next;
            w2_reg  <= w2_next;
            s3_reg  <= s3_next;
            res_reg <= res_next;
        end
    end
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the double bitwise-NOT pipeline.
`timescale 1ns / 1ps

class not_scoreboard;
    bit [63:0] pending_q[$];
    int        errors;

    // Predict the result for one operand.
    static function bit [63:0] predict_not(bit [63:0] x);
        bit [10:0] expf;
        int        e, shift, p, idx, ex;
        bit [63:0] mant, t;
        bit [31:0] low, v;
        expf = x[62:52];
        if (expf == 11'h7FF) begin
            if (x[63]) return 64'd0;
            return {1'b0, 11'd1054, 52'hFFFFF_FFE0_0000};
        end
        e = int'(expf) - 1023;
        mant = {11'd0, 1'b1, x[51:0]};
        if (e >= 0 && (e >= 52 || (x << (e + 12)) == 64'd0)) begin
            if (e >= 52) begin
                low = (e - 52 >= 32) ? 32'd0 : 32'(mant << (e - 52));
            end else begin
                low = 32'(mant >> (52 - e));
            end
            if (x[63]) low = 32'd0 - low;
            v = ~low;
            if (v == 0) return 64'd0;
            p = 0;
            for (int i = 0; i < 32; i++) if (v[i]) p = i;
            t = ({32'd0, v} << (52 - p));
            return {1'b0, 11'(1023 + p), t[51:0]};
        end
        shift = 31 - e;
        if (shift >= 0) mant = (shift <= 52) ? (mant >> shift) : 64'd0;
        else if (-shift >= 64) mant = 64'd0;
        else mant = mant << (-shift);
        if (x[63] && x[62:0] != 0) mant = 64'd0 - mant;
        mant = ~mant;
        ex = 1054;
        if (!mant[52]) begin
            mant = mant & 64'h001F_FFFF_FFFF_FFFF;
            if (mant == 0) return 64'd0;
            p = 0;
            for (int i = 0; i < 53; i++) if (mant[i]) p = i;
            idx = 52 - p;
            ex = ex - idx;
            mant = mant << idx;
        end
        return {1'b0, 11'(ex), mant[51:0]};
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    function void note_operand(bit [63:0] x);
        pending_q.push_back(predict_not(x));
    endfunction

    task check_result(bit [63:0] got);
        bit [63:0] want;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        want = pending_q.pop_front();
        if (got !== want) begin
            report($sformatf("result_bits got %h want %h", got, want));
        end
    endtask
endclass

module testbench;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [63:0] s_operand_bits = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [63:0] m_result_bits;
    int          send_idle, recv_idle;
    not_scoreboard sb;

    double_fixed_point_bitwise_not dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_operand_bits(s_operand_bits), .m_valid(m_valid), .m_ready(m_ready),
        .m_result_bits(m_result_bits)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    // Sample transfers at the edge; inputs change after it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_operand(s_operand_bits);
            if (m_valid && m_ready) sb.check_result(m_result_bits);
        end
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    // Drop valid only while idling, so back-to-back transfers keep it high.
    task automatic send_operand(bit [63:0] x);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_operand_bits <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic bit [63:0] random_operand();
        bit [63:0] x;
        int        k;
        x = {$urandom, $urandom};
        k = $urandom_range(5);
        // Steer the exponent toward the interesting region around the 32-bit word.
        if (k < 3) x[62:52] = 11'(1023 + $urandom_range(62) - 10);
        if (k == 1) x[51:0] = x[51:0] & ~(52'hF_FFFF_FFFF_FFFF >> $urandom_range(52));
        if (k == 3) x[62:52] = $urandom_range(1) ? 11'h7FF : 11'h0;
        return x;
    endfunction

    initial begin
        bit [63:0] directed[$];
        sb = new();
        send_idle = 13;
        recv_idle = 66;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
            64'hBFF0_0000_0000_0000, 64'h41EF_FFFF_FFE0_0000, 64'h41F0_0000_0000_0000,
            64'hC1F0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
            64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
            64'h8000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
            64'h4330_0000_0000_0001, 64'h4530_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
            64'h3EA0_0000_0000_0000, 64'hBEA0_0000_0000_0000, 64'h41E0_0000_0000_0000,
            64'h4000_0000_0000_0001, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
        foreach (directed[i]) send_operand(directed[i]);
        for (int i = 0; i < 650; i++) begin
            if (i == 220) begin
                send_idle = 66;
                recv_idle = 13;
            end
            if (i == 440) begin
                send_idle = 0;
                recv_idle = 0;
            end
            send_operand(random_operand());
        end
        s_valid <= 0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("double_fixed_point_bitwise_not verification clean");
        end else begin
            $display("double_fixed_point_bitwise_not verification failed");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("double_fixed_point_bitwise_not verification failed");
        $finish;
    end
endmodule
